// ===== sv/texture_mip_chain_size_core_macros.svh =====
// ----------------------------------------------------------------------------
// Texture mip chain size core: assertion macros
// Shared concurrent assertion forms; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_MIP_CHAIN_SIZE_CORE_MACROS_SVH
`define TEXTURE_MIP_CHAIN_SIZE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define TMCS_ASSERT_IMP(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("texture_mip_chain_size_core: assertion failed");
// Next-cycle implication, checked out of reset.
`define TMCS_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("texture_mip_chain_size_core: assertion failed");
`else
`define TMCS_ASSERT_IMP(label, clock, rstn, ante, cons)
`define TMCS_ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif

`endif

// ===== sv/tmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture mip chain size package
// Request and response types, format and status codes, and the control store
// of the sizing sequencer.
// ----------------------------------------------------------------------------
package tmcs_pkg;

    // Full chain length is capped at this many levels.
    localparam int MAX_MIP_LEVELS = 17;

    // Format class codes.
    localparam logic [3:0] FC_UNDEF  = 4'd0;
    localparam logic [3:0] FC_ZERO   = 4'd1;
    localparam logic [3:0] FC_BC8    = 4'd8;
    localparam logic [3:0] FC_BC16   = 4'd9;

    // Dimension codes.
    localparam logic [1:0] DIM_3D    = 2'd2;
    localparam logic [1:0] DIM_BAD   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;

    typedef struct packed {
        logic [15:0] tex_width;
        logic [15:0] tex_height;
        logic [11:0] depth_or_layers;
        logic [4:0]  requested_mips;
        logic [1:0]  dimension;
        logic [3:0]  format_class;
    } tex_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  mip_count;
        logic [49:0] total_bytes;
        logic [15:0] subresource_count;
    } tex_rsp_t;

    // Program counter of the sequencer.
    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_CHECK   = 3'd1,
        S_RESOLVE = 3'd2,
        S_ACCUM   = 3'd3,
        S_ADVANCE = 3'd4,
        S_EMIT    = 3'd5
    } step_t;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_CHECK   = 3'd1,
        ACT_RESOLVE = 3'd2,
        ACT_ACCUM   = 3'd3,
        ACT_ADVANCE = 3'd4,
        ACT_EMIT    = 3'd5
    } act_t;

    // Branch condition selected by a control word.
    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_NO_REQ   = 3'd1,
        COND_INVALID  = 3'd2,
        COND_TOO_MANY = 3'd3,
        COND_LVL_DONE = 3'd4,
        COND_OUT_BUSY = 3'd5
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jmp;   // taken when the condition holds
        step_t nxt;   // taken otherwise
    } uword_t;

    // Control store: one word per step.
    function automatic uword_t ucode(step_t pc);
        uword_t w;
        begin
            unique case (pc)
                S_IDLE:    w = '{ACT_LOAD,    COND_NO_REQ,   S_IDLE,  S_CHECK};
                S_CHECK:   w = '{ACT_CHECK,   COND_INVALID,  S_EMIT,  S_RESOLVE};
                S_RESOLVE: w = '{ACT_RESOLVE, COND_TOO_MANY, S_EMIT,  S_ACCUM};
                S_ACCUM:   w = '{ACT_ACCUM,   COND_LVL_DONE, S_EMIT,  S_ADVANCE};
                S_ADVANCE: w = '{ACT_ADVANCE, COND_ALWAYS,   S_ACCUM, S_ACCUM};
                S_EMIT:    w = '{ACT_EMIT,    COND_OUT_BUSY, S_EMIT,  S_IDLE};
                default:   w = '{ACT_LOAD,    COND_ALWAYS,   S_IDLE,  S_IDLE};
            endcase
            return w;
        end
    endfunction

    // Number of significant bits of a nonzero value.
    function automatic logic [4:0] bit_len(logic [15:0] v);
        logic [4:0] len;
        begin
            len = '0;
            for (int i = 0; i < 16; i++)
            begin
                if (v[i])
                begin
                    len = 5'(i + 1);
                end
            end
            return len;
        end
    endfunction

endpackage

// ===== sv/texture_mip_chain_size_core.sv =====
// ----------------------------------------------------------------------------
// Texture mip chain size core
// Resolves the mip count of a texture and sums the byte size and number of
// all its two-dimensional subresources, under control of a small microcode.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  req       in         req_valid/req_stall   tex_req_t
//  rsp       out        rsp_valid/rsp_stall   tex_rsp_t
//
// A valid request runs the two-step level loop (one multiply in each step) of
// the sequencer, accumulate and advance, for each level before the response.
// An invalid request jumps to emit from check; too many mips, from resolve.
// Reset clears the step counter and the response valid; no clearing pass.
// A stalled response holds the sequencer in its emit step; a new request is
// accepted as soon as the previous response is registered.

`include "texture_mip_chain_size_core_macros.svh"

module texture_mip_chain_size_core
    import tmcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  tex_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output tex_rsp_t rsp
);

    step_t       pc_reg, pc_next;
    uword_t      uw;
    logic        take;

    logic        rsp_valid_reg, rsp_valid_next;
    tex_rsp_t    rsp_reg;

    tex_req_t    in_reg;
    logic [15:0] cur_w_reg;
    logic [15:0] cur_h_reg;
    logic [11:0] cur_d_reg;
    logic [4:0]  full_reg;
    logic [4:0]  mips_reg;
    logic [4:0]  lvl_reg;
    logic [1:0]  status_reg;
    logic [20:0] row_bytes_reg;
    logic [27:0] rows_x_n_reg;
    logic [48:0] prod_reg;
    logic [49:0] total_reg;
    logic [16:0] count_reg;

    logic        accept;
    logic        out_busy;
    logic        invalid;
    logic        too_many;
    logic        lvl_done;
    logic        is_bc;
    logic [4:0]  full_len;
    logic [4:0]  mips_pick;
    logic [16:0] bw_sum;
    logic [16:0] bh_sum;
    logic [23:0] bits_w;
    logic [23:0] bits_round;
    logic [20:0] row_bytes;
    logic [15:0] rows;
    logic [11:0] layers;
    logic [27:0] rows_x_n;
    logic [15:0] count_sat;

    assign uw        = ucode(pc_reg);
    assign req_stall = (uw.act != ACT_LOAD);
    assign accept    = req_valid && !req_stall;
    assign out_busy  = rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Argument checks and mip resolution.
    assign invalid = (in_reg.tex_width == '0) || (in_reg.tex_height == '0)
                  || (in_reg.depth_or_layers == '0) || (in_reg.format_class == FC_UNDEF)
                  || (in_reg.format_class > FC_BC16) || (in_reg.dimension == DIM_BAD);
    assign full_len = (bit_len(in_reg.tex_width) > bit_len(in_reg.tex_height))
                    ? bit_len(in_reg.tex_width) : bit_len(in_reg.tex_height);
    assign too_many = (in_reg.requested_mips > 5'd1) && (in_reg.requested_mips > full_reg);
    assign mips_pick = (in_reg.requested_mips == 5'd0) ? full_reg : in_reg.requested_mips;
    assign lvl_done  = (lvl_reg == mips_reg);

    // Slice size of the current level, split as row bytes times row count.
    assign is_bc      = (in_reg.format_class == FC_BC8) || (in_reg.format_class == FC_BC16);
    assign bw_sum     = {1'b0, cur_w_reg} + 17'd3;
    assign bh_sum     = {1'b0, cur_h_reg} + 17'd3;
    assign bits_w     = {8'b0, cur_w_reg} << in_reg.format_class[2:0];
    assign bits_round = bits_w + 24'd7;

    always_comb
    begin
        priority if (is_bc)
        begin
            row_bytes = (in_reg.format_class == FC_BC8) ? {3'b0, bw_sum[16:2], 3'b0}
                                                        : {2'b0, bw_sum[16:2], 4'b0};
            rows      = {1'b0, bh_sum[16:2]};
        end
        else if (in_reg.format_class == FC_ZERO)
        begin
            row_bytes = '0;
            rows      = cur_h_reg;
        end
        else
        begin
            row_bytes = bits_round[23:3];
            rows      = cur_h_reg;
        end
    end

    assign layers    = (in_reg.dimension == DIM_3D) ? cur_d_reg : in_reg.depth_or_layers;
    assign rows_x_n  = {12'b0, rows} * {16'b0, layers};
    assign count_sat = count_reg[16] ? 16'hFFFF : count_reg[15:0];

    always_comb
    begin
        unique case (uw.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_NO_REQ:   take = !req_valid;
            COND_INVALID:  take = invalid;
            COND_TOO_MANY: take = too_many;
            COND_LVL_DONE: take = lvl_done;
            COND_OUT_BUSY: take = out_busy;
            default:       take = 1'b1;
        endcase
        pc_next = take ? uw.jmp : uw.nxt;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if ((uw.act == ACT_EMIT) && !out_busy)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (uw.act)
            ACT_LOAD:
            begin
                if (accept)
                begin
                    in_reg     <= req;
                    cur_w_reg  <= req.tex_width;
                    cur_h_reg  <= req.tex_height;
                    cur_d_reg  <= req.depth_or_layers;
                    mips_reg   <= '0;
                    total_reg  <= '0;
                    count_reg  <= '0;
                end
            end
            ACT_CHECK:
            begin
                status_reg <= invalid ? ST_INVALID : ST_OK;
                full_reg   <= ({1'b0, full_len} > 6'(MAX_MIP_LEVELS))
                            ? 5'(MAX_MIP_LEVELS) : full_len;
            end
            ACT_RESOLVE:
            begin
                if (too_many)
                begin
                    status_reg <= ST_TOO_MANY;
                end
                else
                begin
                    mips_reg <= mips_pick;
                end
                lvl_reg  <= '0;
                prod_reg <= '0;
            end
            ACT_ACCUM:
            begin
                // The product of the previous level lands here, also on exit.
                total_reg <= total_reg + {1'b0, prod_reg};
                if (!lvl_done)
                begin
                    row_bytes_reg <= row_bytes;
                    rows_x_n_reg  <= rows_x_n;
                    count_reg     <= count_reg + {5'b0, layers};
                end
            end
            ACT_ADVANCE:
            begin
                prod_reg <= 49'(row_bytes_reg) * 49'(rows_x_n_reg);
                lvl_reg  <= lvl_reg + 5'd1;
                if (cur_w_reg > 16'd1)
                begin
                    cur_w_reg <= cur_w_reg >> 1;
                end
                if (cur_h_reg > 16'd1)
                begin
                    cur_h_reg <= cur_h_reg >> 1;
                end
                if ((in_reg.dimension == DIM_3D) && (cur_d_reg > 12'd1))
                begin
                    cur_d_reg <= cur_d_reg >> 1;
                end
            end
            ACT_EMIT:
            begin
                if (!out_busy)
                begin
                    rsp_reg.status            <= status_reg;
                    rsp_reg.mip_count         <= mips_reg;
                    rsp_reg.total_bytes       <= total_reg;
                    rsp_reg.subresource_count <= count_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    `TMCS_ASSERT_NEXT(a_accept_to_check, clk, rst_n, accept, pc_reg == S_CHECK)
    `TMCS_ASSERT_IMP(a_rsp_from_emit, clk, rst_n, $rose(rsp_valid), $past(pc_reg == S_EMIT))
    `TMCS_ASSERT_IMP(a_lvl_in_range, clk, rst_n, (pc_reg == S_ACCUM) || (pc_reg == S_ADVANCE), lvl_reg <= mips_reg)
    `TMCS_ASSERT_IMP(a_error_zero, clk, rst_n, rsp_valid && (rsp.status != ST_OK), (rsp.mip_count == '0) && (rsp.total_bytes == '0) && (rsp.subresource_count == '0))

endmodule
